FILE: design/lgge_pkg.sv
`default_nettype none

package lgge_pkg;

  localparam int COORD_W  = 6;
  localparam int OFFSET_W = 32;
  localparam int RULE_W   = 18;
  localparam int RULE_IDX_W = 5;
  localparam logic [RULE_W-1:0] RULE_RESET = 18'd6152;
  localparam logic [RULE_IDX_W-1:0] SURVIVE_BASE = 5'd9;

  typedef enum logic [2:0] {
    REQ_CLEAR      = 3'd0,
    REQ_WRITE_NEXT = 3'd1,
    REQ_READ_SHOWN = 3'd2,
    REQ_READ_NEXT  = 3'd3,
    REQ_STEP       = 3'd4,
    REQ_SWAP       = 3'd5,
    REQ_EMPTY      = 3'd6,
    REQ_LIST       = 3'd7
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SWAP,
    ST_RD,
    ST_MODIFY,
    ST_RESP,
    ST_SCAN0,
    ST_SCAN1,
    ST_CELL,
    ST_LIST_END
  } state_t;

  typedef struct packed {
    logic               load;
    logic               clear;
    logic               swap;
    logic               rd_en;
    logic               rd_next;
    logic               rd_cell;
    logic [COORD_W-1:0] rd_row;
    logic               wr_cell;
    logic               scan_init;
    logic               scan_cell;
    logic               row_end;
    logic               list_mode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               emit_resp;
    logic               emit_list_end;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/lgge_plane.sv
`default_nettype none

module lgge_plane #(
  parameter int GRID_SIZE = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        clear,
  input  wire logic                        rd_en,
  input  wire logic [lgge_pkg::COORD_W-1:0] rd_row,
  output logic [GRID_SIZE-1:0]             rd_data,
  input  wire logic                        wr_en,
  input  wire logic [lgge_pkg::COORD_W-1:0] wr_row,
  input  wire logic [GRID_SIZE-1:0]        wr_data,
  output logic                             nonzero
);

  localparam int RW = $clog2(GRID_SIZE);

  logic [GRID_SIZE-1:0] mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] valid;
  logic [GRID_SIZE-1:0] nz;
  logic [GRID_SIZE-1:0] q;
  logic                 q_ok;
  logic                 rd_in;
  logic                 wr_in;
  logic [RW-1:0]        ridx;
  logic [RW-1:0]        widx;

  assign rd_in = rd_row < lgge_pkg::COORD_W'(GRID_SIZE);
  assign wr_in = wr_row < lgge_pkg::COORD_W'(GRID_SIZE);
  assign ridx  = rd_in ? rd_row[RW-1:0] : '0;
  assign widx  = wr_in ? wr_row[RW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (wr_en && wr_in) begin
      mem[widx] <= wr_data;
    end
    if (rd_en) begin
      q <= mem[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
      nz    <= '0;
    end else if (wr_en && wr_in) begin
      valid[widx] <= 1'b1;
      nz[widx]    <= |wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_ok <= 1'b0;
    end else if (rd_en) begin
      q_ok <= rd_in && valid[ridx];
    end
  end

  assign rd_data = q_ok ? q : '0;
  assign nonzero = |nz;

endmodule

`default_nettype wire

FILE: design/lgge_ctrl.sv
`default_nettype none

module lgge_ctrl #(
  parameter int GRID_SIZE = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [2:0]           req_type,
  output logic                      busy,
  output lgge_pkg::cmd_t            cmd
);

  localparam int CW = $clog2(GRID_SIZE);
  localparam logic [CW-1:0] LAST_IDX = CW'(GRID_SIZE - 1);

  lgge_pkg::state_t state, state_next;
  logic [CW-1:0]    x, x_next;
  logic [CW-1:0]    y, y_next;
  logic             is_list, is_list_next;
  logic             is_write, is_write_next;
  logic             rd_next, rd_next_next;
  lgge_pkg::req_t   req;

  assign req  = lgge_pkg::req_t'(req_type);
  assign busy = state != lgge_pkg::ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lgge_pkg::ST_IDLE;
      x        <= '0;
      y        <= '0;
      is_list  <= 1'b0;
      is_write <= 1'b0;
      rd_next  <= 1'b0;
    end else begin
      state    <= state_next;
      x        <= x_next;
      y        <= y_next;
      is_list  <= is_list_next;
      is_write <= is_write_next;
      rd_next  <= rd_next_next;
    end
  end

  always_comb begin
    state_next    = state;
    x_next        = x;
    y_next        = y;
    is_list_next  = is_list;
    is_write_next = is_write;
    rd_next_next  = rd_next;
    cmd           = '0;
    cmd.x         = lgge_pkg::COORD_W'(x);
    cmd.y         = lgge_pkg::COORD_W'(y);
    cmd.list_mode = is_list;
    unique case (state)
      lgge_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load      = 1'b1;
          is_list_next  = req == lgge_pkg::REQ_LIST;
          is_write_next = req == lgge_pkg::REQ_WRITE_NEXT;
          rd_next_next  = req != lgge_pkg::REQ_READ_SHOWN;
          unique case (req)
            lgge_pkg::REQ_CLEAR:      state_next = lgge_pkg::ST_CLEAR;
            lgge_pkg::REQ_WRITE_NEXT,
            lgge_pkg::REQ_READ_SHOWN,
            lgge_pkg::REQ_READ_NEXT:  state_next = lgge_pkg::ST_RD;
            lgge_pkg::REQ_STEP,
            lgge_pkg::REQ_LIST:       state_next = lgge_pkg::ST_SCAN0;
            lgge_pkg::REQ_SWAP:       state_next = lgge_pkg::ST_SWAP;
            lgge_pkg::REQ_EMPTY:      state_next = lgge_pkg::ST_RESP;
            default:                  state_next = lgge_pkg::ST_RESP;
          endcase
        end
      end
      lgge_pkg::ST_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = lgge_pkg::ST_RESP;
      end
      lgge_pkg::ST_SWAP: begin
        cmd.swap   = 1'b1;
        state_next = lgge_pkg::ST_RESP;
      end
      lgge_pkg::ST_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_next = rd_next;
        cmd.rd_cell = 1'b1;
        state_next  = is_write ? lgge_pkg::ST_MODIFY : lgge_pkg::ST_RESP;
      end
      lgge_pkg::ST_MODIFY: begin
        cmd.wr_cell = 1'b1;
        state_next  = lgge_pkg::ST_RESP;
      end
      lgge_pkg::ST_RESP: begin
        cmd.emit_resp = 1'b1;
        state_next    = lgge_pkg::ST_IDLE;
      end
      lgge_pkg::ST_SCAN0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_row = '0;
        x_next     = '0;
        y_next     = '0;
        state_next = lgge_pkg::ST_SCAN1;
      end
      lgge_pkg::ST_SCAN1: begin
        cmd.scan_init = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_row    = lgge_pkg::COORD_W'(1);
        state_next    = lgge_pkg::ST_CELL;
      end
      lgge_pkg::ST_CELL: begin
        cmd.scan_cell = 1'b1;
        if (x == LAST_IDX) begin
          // row done: shift window and prefetch the row two below
          cmd.row_end = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_row  = lgge_pkg::COORD_W'(y) + lgge_pkg::COORD_W'(2);
          x_next      = '0;
          y_next      = y + CW'(1);
          if (y == LAST_IDX) begin
            state_next = is_list ? lgge_pkg::ST_LIST_END : lgge_pkg::ST_RESP;
          end
        end else begin
          x_next = x + CW'(1);
        end
      end
      lgge_pkg::ST_LIST_END: begin
        cmd.emit_list_end = 1'b1;
        state_next        = lgge_pkg::ST_IDLE;
      end
      default: begin
        state_next = lgge_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/lgge_datapath.sv
`default_nettype none

module lgge_datapath #(
  parameter int GRID_SIZE = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lgge_pkg::cmd_t                cmd,
  input  wire logic [2:0]                    req_type,
  input  wire logic [lgge_pkg::COORD_W-1:0]  cell_x,
  input  wire logic [lgge_pkg::COORD_W-1:0]  cell_y,
  input  wire logic                          write_bit,
  input  wire logic [lgge_pkg::OFFSET_W-1:0] offset_x,
  input  wire logic [lgge_pkg::OFFSET_W-1:0] offset_y,
  input  wire logic                          cfg_write,
  input  wire logic [lgge_pkg::RULE_W-1:0]   cfg_data,
  output logic                               result_valid,
  output logic                               read_bit,
  output logic                               board_empty,
  output logic                               found,
  output logic [lgge_pkg::OFFSET_W-1:0]      live_x,
  output logic [lgge_pkg::OFFSET_W-1:0]      live_y,
  output logic                               last
);

  localparam int CW = $clog2(GRID_SIZE);
  localparam int PW = GRID_SIZE + 2;

  logic [lgge_pkg::RULE_W-1:0]   rule;
  logic                          shown;
  lgge_pkg::req_t                req;
  logic [lgge_pkg::COORD_W-1:0]  cx;
  logic [lgge_pkg::COORD_W-1:0]  cy;
  logic                          wb;
  logic [lgge_pkg::OFFSET_W-1:0] ox;
  logic [lgge_pkg::OFFSET_W-1:0] oy;

  logic [GRID_SIZE-1:0] above;
  logic [GRID_SIZE-1:0] mid;
  logic [GRID_SIZE-1:0] new_row;
  logic [GRID_SIZE-1:0] rd_q;
  logic [GRID_SIZE-1:0] q0;
  logic [GRID_SIZE-1:0] q1;
  logic                 rd_sel;
  logic                 nz0;
  logic                 nz1;

  logic                          pend_v;
  logic [lgge_pkg::OFFSET_W-1:0] pend_x;
  logic [lgge_pkg::OFFSET_W-1:0] pend_y;

  logic                          rd_plane;
  logic [lgge_pkg::COORD_W-1:0]  rd_row;
  logic                          cell_in;
  logic [CW-1:0]                 cxi;
  logic [CW-1:0]                 xi;
  logic [PW-1:0]                 pa;
  logic [PW-1:0]                 pm;
  logic [PW-1:0]                 pb;
  logic [2:0]                    na;
  logic [2:0]                    nm;
  logic [2:0]                    nb;
  logic [3:0]                    cnt;
  logic [lgge_pkg::RULE_IDX_W-1:0] ridx;
  logic                          nbit;
  logic [GRID_SIZE-1:0]          step_row;
  logic [GRID_SIZE-1:0]          cell_row;
  logic                          wr_en;
  logic [lgge_pkg::COORD_W-1:0]  wr_row;
  logic [GRID_SIZE-1:0]          wr_data;
  logic                          live;
  logic                          empty;
  logic [lgge_pkg::OFFSET_W-1:0] cur_x;
  logic [lgge_pkg::OFFSET_W-1:0] cur_y;

  assign rd_plane = cmd.rd_next ? ~shown : shown;
  assign rd_row   = cmd.rd_cell ? cy : cmd.rd_row;
  assign rd_q     = rd_sel ? q1 : q0;
  assign cell_in  = (cx < lgge_pkg::COORD_W'(GRID_SIZE)) &&
                    (cy < lgge_pkg::COORD_W'(GRID_SIZE));
  assign cxi      = cell_in ? cx[CW-1:0] : '0;
  assign xi       = cmd.x[CW-1:0];
  assign empty    = ~(nz0 | nz1);

  // neighbour count for the cell at xi of the middle row
  assign pa = {1'b0, above, 1'b0};
  assign pm = {1'b0, mid, 1'b0};
  assign pb = {1'b0, rd_q, 1'b0};
  assign na = pa[xi +: 3];
  assign nm = pm[xi +: 3];
  assign nb = pb[xi +: 3];
  assign cnt = {3'b0, na[0]} + {3'b0, na[1]} + {3'b0, na[2]} + {3'b0, nm[0]} +
               {3'b0, nm[2]} + {3'b0, nb[0]} + {3'b0, nb[1]} + {3'b0, nb[2]};
  assign ridx = nm[1] ? lgge_pkg::SURVIVE_BASE + {1'b0, cnt} : {1'b0, cnt};
  assign nbit = rule[ridx];
  assign live = nm[1];

  assign cur_x = lgge_pkg::OFFSET_W'(cmd.x) + ox;
  assign cur_y = lgge_pkg::OFFSET_W'(cmd.y) + oy;

  always_comb begin
    step_row      = new_row;
    step_row[xi]  = nbit;
    cell_row      = rd_q;
    cell_row[cxi] = wb;
  end

  assign wr_en   = (cmd.wr_cell && cell_in) || (cmd.row_end && !cmd.list_mode);
  assign wr_row  = cmd.wr_cell ? cy : cmd.y;
  assign wr_data = cmd.wr_cell ? cell_row : step_row;

  lgge_plane #(.GRID_SIZE(GRID_SIZE)) u_plane0 (
    .clk     (clk),
    .rst     (rst),
    .clear   (cmd.clear),
    .rd_en   (cmd.rd_en && !rd_plane),
    .rd_row  (rd_row),
    .rd_data (q0),
    .wr_en   (wr_en && shown),
    .wr_row  (wr_row),
    .wr_data (wr_data),
    .nonzero (nz0)
  );

  lgge_plane #(.GRID_SIZE(GRID_SIZE)) u_plane1 (
    .clk     (clk),
    .rst     (rst),
    .clear   (cmd.clear),
    .rd_en   (cmd.rd_en && rd_plane),
    .rd_row  (rd_row),
    .rd_data (q1),
    .wr_en   (wr_en && !shown),
    .wr_row  (wr_row),
    .wr_data (wr_data),
    .nonzero (nz1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rule   <= lgge_pkg::RULE_RESET;
      shown  <= 1'b0;
      rd_sel <= 1'b0;
      pend_v <= 1'b0;
      req    <= lgge_pkg::REQ_CLEAR;
    end else begin
      if (cfg_write) begin
        rule <= cfg_data;
      end
      if (cmd.clear) begin
        shown <= 1'b0;
      end else if (cmd.swap) begin
        shown <= ~shown;
      end
      if (cmd.rd_en) begin
        rd_sel <= rd_plane;
      end
      if (cmd.load) begin
        req <= lgge_pkg::req_t'(req_type);
      end
      if (cmd.scan_init) begin
        pend_v <= 1'b0;
      end else if (cmd.scan_cell && cmd.list_mode && live) begin
        pend_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx <= cell_x;
      cy <= cell_y;
      wb <= write_bit;
      ox <= offset_x;
      oy <= offset_y;
    end
    if (cmd.scan_init) begin
      above <= '0;
      mid   <= rd_q;
    end else if (cmd.row_end) begin
      above <= mid;
      mid   <= rd_q;
    end
    if (cmd.scan_cell) begin
      new_row[xi] <= nbit;
    end
    if (cmd.scan_cell && cmd.list_mode && live) begin
      pend_x <= cur_x;
      pend_y <= cur_y;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_resp || cmd.emit_list_end ||
                      (cmd.scan_cell && cmd.list_mode && live && pend_v);
    end
  end

  always_ff @(posedge clk) begin
    board_empty <= empty;
    if (cmd.emit_resp) begin
      read_bit <= (req == lgge_pkg::REQ_READ_SHOWN || req == lgge_pkg::REQ_READ_NEXT) &&
                  cell_in && rd_q[cxi];
      found    <= 1'b0;
      live_x   <= '0;
      live_y   <= '0;
      last     <= 1'b1;
    end else if (cmd.emit_list_end) begin
      read_bit <= 1'b0;
      found    <= pend_v;
      live_x   <= pend_v ? pend_x : '0;
      live_y   <= pend_v ? pend_y : '0;
      last     <= 1'b1;
    end else begin
      read_bit <= 1'b0;
      found    <= 1'b1;
      live_x   <= pend_x;
      live_y   <= pend_y;
      last     <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: design/life_grid_generation_engine_top.sv
// Life grid generation engine: two GRID_SIZE x GRID_SIZE cell planes with a
// dead border, a shown plane and a next plane.
// Command channel: a word is taken at a clock edge where start is high and
// busy is low. req_type selects clear, write next, read shown, read next,
// step, swap, empty test or list.
// Config channel: cfg_data is written to the 18-bit rule table when cfg_valid
// and cfg_ready are both high; cfg_ready is high while no command is running.
// Results: each result word is on the result ports for one cycle with
// result_valid high; last marks the final word of a command. The receiver
// cannot stall, so no result is ever held back.
// Clear and swap pass their own state and then the response state; an empty
// test goes straight to it; reads pass a read state, writes a modify state too.
// Step and list scan one interior cell per cycle through the neighbour count
// unit; the final word is on the ports in the first cycle with busy low. List
// words stream out during the scan, each one delayed until the next live cell
// or the end of the scan is seen.
// Reset (rst, synchronous) empties both planes at once, shows plane 0 and
// loads the B3/S23 rule.
`default_nettype none

module life_grid_generation_engine_top #(
  parameter int GRID_SIZE = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    req_type,
  input  wire logic [lgge_pkg::COORD_W-1:0]  cell_x,
  input  wire logic [lgge_pkg::COORD_W-1:0]  cell_y,
  input  wire logic                          write_bit,
  input  wire logic [lgge_pkg::OFFSET_W-1:0] offset_x,
  input  wire logic [lgge_pkg::OFFSET_W-1:0] offset_y,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lgge_pkg::RULE_W-1:0]   cfg_data,
  output logic                               result_valid,
  output logic                               read_bit,
  output logic                               board_empty,
  output logic                               found,
  output logic [lgge_pkg::OFFSET_W-1:0]      live_x,
  output logic [lgge_pkg::OFFSET_W-1:0]      live_y,
  output logic                               last
);

  lgge_pkg::cmd_t cmd;

  assign cfg_ready = ~busy;

  lgge_ctrl #(.GRID_SIZE(GRID_SIZE)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .busy     (busy),
    .cmd      (cmd)
  );

  lgge_datapath #(.GRID_SIZE(GRID_SIZE)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_type     (req_type),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .write_bit    (write_bit),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .read_bit     (read_bit),
    .board_empty  (board_empty),
    .found        (found),
    .live_x       (live_x),
    .live_y       (live_y),
    .last         (last)
  );

endmodule

`default_nettype wire

FILE: bench/life_grid_checker.sv
module life_grid_checker #(
  parameter int GRID_SIZE = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [2:0]                    req_type,
  input  logic [lgge_pkg::COORD_W-1:0]  cell_x,
  input  logic [lgge_pkg::COORD_W-1:0]  cell_y,
  input  logic                          write_bit,
  input  logic [lgge_pkg::OFFSET_W-1:0] offset_x,
  input  logic [lgge_pkg::OFFSET_W-1:0] offset_y,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lgge_pkg::RULE_W-1:0]   cfg_data,
  input  logic                          result_valid,
  input  logic                          read_bit,
  input  logic                          board_empty,
  input  logic                          found,
  input  logic [lgge_pkg::OFFSET_W-1:0] live_x,
  input  logic [lgge_pkg::OFFSET_W-1:0] live_y,
  input  logic                          last,
  output int                            fail_count,
  output int                            words_pending
);
  import lgge_pkg::*;

  localparam int PAD   = GRID_SIZE + 2;
  localparam int CELLS = PAD * PAD;

  typedef struct packed {
    logic                read_bit;
    logic                board_empty;
    logic                found;
    logic [OFFSET_W-1:0] live_x;
    logic [OFFSET_W-1:0] live_y;
    logic                last;
  } result_word_t;

  result_word_t      expected_words[$];
  result_word_t      got_word;
  logic [CELLS-1:0]  plane[2];
  logic              shown_sel;
  logic [RULE_W-1:0] rule_bits;

  function automatic int cell_index(int x, int y);
    return (y + 1) * PAD + x + 1;
  endfunction

  task automatic push_word(logic rb, logic fnd, logic [OFFSET_W-1:0] lx,
                           logic [OFFSET_W-1:0] ly, logic lst);
    result_word_t w;
    w.read_bit    = rb;
    w.board_empty = (plane[0] == '0) && (plane[1] == '0);
    w.found       = fnd;
    w.live_x      = lx;
    w.live_y      = ly;
    w.last        = lst;
    expected_words.push_back(w);
  endtask

  task automatic next_generation();
    logic [CELLS-1:0] src;
    int s;
    int c;
    int cnt;
    s   = int'(shown_sel);
    src = plane[s];
    for (int y = 0; y < GRID_SIZE; y++) begin
      for (int x = 0; x < GRID_SIZE; x++) begin
        c   = cell_index(x, y);
        cnt = 0;
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            if (dx != 0 || dy != 0) cnt += int'(src[c + dy * PAD + dx]);
          end
        end
        if (src[c]) cnt += int'(SURVIVE_BASE);
        plane[s ^ 1][c] = rule_bits[cnt];
      end
    end
  endtask

  task automatic predict(logic [2:0] req, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                         logic wb, logic [OFFSET_W-1:0] ox, logic [OFFSET_W-1:0] oy);
    int   s;
    int   n;
    int   live_total;
    int   k;
    logic in_grid;
    logic rb;
    s       = int'(shown_sel);
    n       = s ^ 1;
    in_grid = (int'(x) < GRID_SIZE) && (int'(y) < GRID_SIZE);
    rb      = 1'b0;
    case (req_t'(req))
      REQ_CLEAR: begin
        plane[0]  = '0;
        plane[1]  = '0;
        shown_sel = 1'b0;
      end
      REQ_WRITE_NEXT: if (in_grid) plane[n][cell_index(int'(x), int'(y))] = wb;
      REQ_READ_SHOWN: if (in_grid) rb = plane[s][cell_index(int'(x), int'(y))];
      REQ_READ_NEXT:  if (in_grid) rb = plane[n][cell_index(int'(x), int'(y))];
      REQ_STEP:       next_generation();
      REQ_SWAP:       shown_sel = ~shown_sel;
      default: ;
    endcase
    if (req_t'(req) == REQ_LIST) begin
      live_total = 0;
      for (int cy = 0; cy < GRID_SIZE; cy++) begin
        for (int cx = 0; cx < GRID_SIZE; cx++) begin
          if (plane[s][cell_index(cx, cy)]) live_total++;
        end
      end
      if (live_total == 0) begin
        push_word(1'b0, 1'b0, '0, '0, 1'b1);
      end else begin
        k = 0;
        for (int cy = 0; cy < GRID_SIZE; cy++) begin
          for (int cx = 0; cx < GRID_SIZE; cx++) begin
            if (plane[s][cell_index(cx, cy)]) begin
              k++;
              push_word(1'b0, 1'b1, OFFSET_W'(cx) + ox, OFFSET_W'(cy) + oy,
                        k == live_total);
            end
          end
        end
      end
    end else begin
      push_word(rb, 1'b0, '0, '0, 1'b1);
    end
  endtask

  task automatic check_field(string name, logic [OFFSET_W-1:0] exp_val,
                             logic [OFFSET_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      plane[0]   = '0;
      plane[1]   = '0;
      shown_sel  = 1'b0;
      rule_bits  = RULE_RESET;
      fail_count = 0;
      expected_words.delete();
    end else begin
      if (result_valid) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          got_word = expected_words.pop_front();
          check_field("read_bit", OFFSET_W'(got_word.read_bit), OFFSET_W'(read_bit));
          check_field("board_empty", OFFSET_W'(got_word.board_empty),
                      OFFSET_W'(board_empty));
          check_field("found", OFFSET_W'(got_word.found), OFFSET_W'(found));
          check_field("live_x", got_word.live_x, live_x);
          check_field("live_y", got_word.live_y, live_y);
          check_field("last", OFFSET_W'(got_word.last), OFFSET_W'(last));
        end
      end
      if (cfg_valid && cfg_ready) rule_bits = cfg_data;
      if (start && !busy) predict(req_type, cell_x, cell_y, write_bit, offset_x, offset_y);
    end
    words_pending <= expected_words.size();
  end

endmodule

FILE: bench/tb_life_grid_generation_engine_top.sv
module tb_life_grid_generation_engine_top;
  import lgge_pkg::*;

  localparam int GRID_SIZE   = 6;
  localparam int CYCLE_LIMIT = 300000;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  logic [2:0]          req_type  = '0;
  logic [COORD_W-1:0]  cell_x    = '0;
  logic [COORD_W-1:0]  cell_y    = '0;
  logic                write_bit = 1'b0;
  logic [OFFSET_W-1:0] offset_x  = '0;
  logic [OFFSET_W-1:0] offset_y  = '0;
  logic                cfg_valid = 1'b0;
  logic [RULE_W-1:0]   cfg_data  = '0;

  logic                busy;
  logic                cfg_ready;
  logic                result_valid;
  logic                read_bit;
  logic                board_empty;
  logic                found;
  logic [OFFSET_W-1:0] live_x;
  logic [OFFSET_W-1:0] live_y;
  logic                last;

  int fail_count;
  int words_pending;
  int cycles  = 0;
  bit gaps_on = 1'b1;

  logic [RULE_W-1:0] phase_rules[6];

  life_grid_generation_engine_top #(.GRID_SIZE(GRID_SIZE)) dut (.*);

  life_grid_checker #(.GRID_SIZE(GRID_SIZE)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic issue(logic [2:0] req, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                       logic wb, logic [OFFSET_W-1:0] ox, logic [OFFSET_W-1:0] oy);
    start     <= 1'b1;
    req_type  <= req;
    cell_x    <= x;
    cell_y    <= y;
    write_bit <= wb;
    offset_x  <= ox;
    offset_y  <= oy;
    do @(posedge clk); while (busy);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  task automatic write_rule(logic [RULE_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int                  pick;
    logic [2:0]          req;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic                wb;
    logic [OFFSET_W-1:0] ox;
    logic [OFFSET_W-1:0] oy;
    pick = $urandom_range(0, 99);
    if (pick < 30)      req = REQ_WRITE_NEXT;
    else if (pick < 42) req = REQ_STEP;
    else if (pick < 54) req = REQ_SWAP;
    else if (pick < 64) req = REQ_LIST;
    else if (pick < 72) req = REQ_READ_SHOWN;
    else if (pick < 80) req = REQ_READ_NEXT;
    else if (pick < 87) req = REQ_EMPTY;
    else if (pick < 90) req = REQ_CLEAR;
    else                req = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) begin
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
    end else begin
      x = COORD_W'($urandom_range(0, GRID_SIZE - 1));
      y = COORD_W'($urandom_range(0, GRID_SIZE - 1));
    end
    wb = ($urandom_range(0, 2) != 0);
    ox = ($urandom_range(0, 3) == 0) ? ~OFFSET_W'($urandom_range(0, 7)) : $urandom;
    oy = ($urandom_range(0, 3) == 0) ? ~OFFSET_W'($urandom_range(0, 7)) : $urandom;
    issue(req, x, y, wb, ox, oy);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    issue(REQ_EMPTY, 6'd0, 6'd0, 1'b0, '0, '0);
    issue(REQ_LIST, 6'd0, 6'd0, 1'b0, 32'd5, 32'd7);
    issue(REQ_READ_SHOWN, 6'd0, 6'd0, 1'b0, '0, '0);
    issue(REQ_WRITE_NEXT, 6'd0, 6'd0, 1'b1, '0, '0);
    issue(REQ_WRITE_NEXT, 6'(GRID_SIZE - 1), 6'(GRID_SIZE - 1), 1'b1, '0, '0);
    issue(REQ_WRITE_NEXT, 6'(GRID_SIZE), 6'd0, 1'b1, '0, '0);
    issue(REQ_WRITE_NEXT, 6'd63, 6'd63, 1'b1, '0, '0);
    issue(REQ_READ_NEXT, 6'd0, 6'd0, 1'b0, '0, '0);
    issue(REQ_READ_NEXT, 6'(GRID_SIZE), 6'd0, 1'b0, '0, '0);
    issue(REQ_EMPTY, 6'd0, 6'd0, 1'b0, '0, '0);
    issue(REQ_SWAP, 6'd0, 6'd0, 1'b0, '0, '0);
    issue(REQ_READ_SHOWN, 6'(GRID_SIZE - 1), 6'(GRID_SIZE - 1), 1'b0, '0, '0);
    issue(REQ_LIST, 6'd0, 6'd0, 1'b0, '1, '1);
    issue(REQ_CLEAR, 6'd0, 6'd0, 1'b0, '0, '0);
    // blinker in the next plane
    issue(REQ_WRITE_NEXT, 6'd1, 6'd2, 1'b1, '0, '0);
    issue(REQ_WRITE_NEXT, 6'd2, 6'd2, 1'b1, '0, '0);
    issue(REQ_WRITE_NEXT, 6'd3, 6'd2, 1'b1, '0, '0);
    issue(REQ_SWAP, 6'd0, 6'd0, 1'b0, '0, '0);
    issue(REQ_STEP, 6'd0, 6'd0, 1'b0, '0, '0);
    issue(REQ_READ_NEXT, 6'd2, 6'd1, 1'b0, '0, '0);
    issue(REQ_SWAP, 6'd0, 6'd0, 1'b0, '0, '0);
    issue(REQ_LIST, 6'd0, 6'd0, 1'b0, 32'h8000_0000, '0);
    issue(REQ_WRITE_NEXT, 6'd2, 6'd2, 1'b0, '0, '0);
    issue(REQ_STEP, 6'd0, 6'd0, 1'b0, '0, '0);
    issue(REQ_READ_SHOWN, 6'd63, 6'd0, 1'b0, '0, '0);
    drain();

    phase_rules[0] = '1;
    phase_rules[1] = '0;
    phase_rules[2] = RULE_W'($urandom);
    phase_rules[3] = RULE_W'($urandom);
    phase_rules[4] = RULE_RESET;
    phase_rules[5] = RULE_W'($urandom);
    for (int phase = 0; phase < 6; phase++) begin
      write_rule(phase_rules[phase]);
      gaps_on = (phase != 5);
      repeat (60) random_item();
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
